// ===== sv/cda_pkg.sv =====
// ----------------------------------------------------------------------------
// cda_pkg
// Shared types, codes and constant-divide helpers for the civil date pipeline.
// ----------------------------------------------------------------------------
package cda_pkg;

  localparam logic [1:0] OP_WEEKDAY    = 2'd0;
  localparam logic [1:0] OP_ADD_DAYS   = 2'd1;
  localparam logic [1:0] OP_ADD_MONTHS = 2'd2;
  localparam logic [1:0] OP_ADD_YEARS  = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_DATE = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;

  localparam logic [13:0] YEAR_MIN  = 14'd1900;
  localparam logic [13:0] YEAR_MAX  = 14'd9999;
  // day count of 10000-01-01
  localparam logic [22:0] DAY_LIMIT = 23'd3652365;
  localparam logic [17:0] ERA_LAST  = 18'd146096;

  typedef struct packed {
    logic [1:0]  op;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [21:0] amount;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [13:0] out_year;
    logic [3:0]  out_month;
    logic [4:0]  out_day;
    logic [2:0]  weekday;
  } rsp_t;

  typedef struct packed {
    logic [21:0] ya365;
    logic [11:0] q4;
    logic [7:0]  q100;
    logic [5:0]  q400;
    logic [8:0]  doy;
  } terms_t;

  function automatic logic [7:0] div100(input logic [13:0] x);
    logic [26:0] p;
    p = 27'(x) * 27'd5243;
    return p[26:19];
  endfunction

  function automatic logic [19:0] div12(input logic [22:0] x);
    logic [45:0] p;
    p = 46'(x) * 46'd5592406;
    return p[45:26];
  endfunction

  function automatic logic [4:0] div146097(input logic [21:0] x);
    logic [43:0] p;
    p = 44'(x) * 44'd3762951;
    return p[43:39];
  endfunction

  function automatic logic [7:0] div1460(input logic [17:0] x);
    logic [35:0] p;
    p = 36'(x) * 36'd183860;
    return p[35:28];
  endfunction

  function automatic logic [2:0] div36524(input logic [17:0] x);
    logic [36:0] p;
    p = 37'(x) * 37'd470373;
    return p[36:34];
  endfunction

  function automatic logic [9:0] div365(input logic [17:0] x);
    logic [35:0] p;
    p = 36'(x) * 36'd183860;
    return p[35:26];
  endfunction

  function automatic logic [3:0] div153(input logic [10:0] x);
    logic [23:0] p;
    p = 24'(x) * 24'd6854;
    return p[23:20];
  endfunction

  function automatic logic [8:0] div5(input logic [10:0] x);
    logic [24:0] p;
    p = 25'(x) * 25'd13108;
    return p[24:16];
  endfunction

  function automatic logic [19:0] div7(input logic [21:0] x);
    logic [44:0] p;
    p = 45'(x) * 45'd4793491;
    return p[44:25];
  endfunction

  function automatic logic leap_of(input logic [13:0] y);
    logic [7:0]  q;
    logic [13:0] r;
    q = div100(y);
    r = y - 14'({6'd0, q} * 14'd100);
    return (y[1:0] == 2'd0) && ((r != 14'd0) || (q[1:0] == 2'd0));
  endfunction

  function automatic logic [4:0] dim_of(input logic [3:0] m, input logic leap);
    case (m)
      4'd2:    return leap ? 5'd29 : 5'd28;
      4'd4:    return 5'd30;
      4'd6:    return 5'd30;
      4'd9:    return 5'd30;
      4'd11:   return 5'd30;
      default: return 5'd31;
    endcase
  endfunction

  // days before month index, year starting in March
  function automatic logic [8:0] cum_days(input logic [3:0] mi);
    case (mi)
      4'd0:    return 9'd0;
      4'd1:    return 9'd31;
      4'd2:    return 9'd61;
      4'd3:    return 9'd92;
      4'd4:    return 9'd122;
      4'd5:    return 9'd153;
      4'd6:    return 9'd184;
      4'd7:    return 9'd214;
      4'd8:    return 9'd245;
      4'd9:    return 9'd275;
      4'd10:   return 9'd306;
      4'd11:   return 9'd337;
      default: return 9'd0;
    endcase
  endfunction

endpackage

// ===== sv/cda_count_terms.sv =====
// ----------------------------------------------------------------------------
// cda_count_terms
// Partial terms of the day count of a date; their sum is days since 0000-03-01.
// ----------------------------------------------------------------------------
module cda_count_terms import cda_pkg::*; (
  input  logic [13:0] y,
  input  logic [3:0]  m,
  input  logic [4:0]  d,
  output terms_t      terms
);

  logic [13:0] ya;
  logic [3:0]  mi;

  assign ya = (m <= 4'd2) ? y - 14'd1 : y;
  assign mi = (m > 4'd2) ? m - 4'd3 : m + 4'd9;

  always_comb begin
    terms.ya365 = 22'({8'd0, ya} * 22'd365);
    terms.q4    = ya[13:2];
    terms.q100  = div100(ya);
    terms.q400  = terms.q100[7:2];
    terms.doy   = cum_days(mi) + 9'(d) - 9'd1;
  end

endmodule

// ===== sv/civil_date_arithmetic.sv =====
// ----------------------------------------------------------------------------
// civil_date_arithmetic
// Gregorian date checker and adder: weekday, add days, months or years.
// ----------------------------------------------------------------------------
// One item enters per cycle while the result side is not stalled; its result
// appears on rsp once it has run through every stage of the pipeline (date
// to day count, count back to a date, clamp, weekday). A stall on the result
// side freezes every stage at once, so nothing is lost or repeated.
module civil_date_arithmetic import cda_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  localparam int NST = 13;

  typedef struct packed {
    logic [1:0]  op;
    logic [13:0] y;
    logic [3:0]  m;
    logic [4:0]  d;
    logic [21:0] amt;
    logic        bad;
    terms_t      tm;
    logic [22:0] total;
    logic [22:0] ry3;
    logic [22:0] csum;
    logic [19:0] q12;
    logic [4:0]  era;
    logic        ovf;
    logic [3:0]  r12;
    logic [17:0] doe;
    logic [7:0]  a1460;
    logic [2:0]  b36524;
    logic        c146096;
    logic [9:0]  yoe;
    logic [8:0]  doyb;
    logic [3:0]  mp;
    logic [13:0] ry;
    logic [3:0]  rm;
    logic [4:0]  rd;
    logic [4:0]  rdp;
    logic [1:0]  status;
    logic [21:0] fcnt;
    logic [19:0] q7;
  } tok_t;

  tok_t           st [NST];
  tok_t           nx [NST];
  logic [NST-1:0] vld;
  logic           adv;
  terms_t         tin;
  terms_t         tout;
  rsp_t           rsp_next;
  logic [21:0]    rem7;
  logic [3:0]     m3;
  logic [4:0]     lim;

  assign adv       = !rsp_valid || rsp_ready;
  assign req_ready = adv;

  cda_count_terms u_terms_in (
    .y     (req.year),
    .m     (req.month),
    .d     (req.day),
    .terms (tin)
  );

  cda_count_terms u_terms_out (
    .y     (st[9].ry),
    .m     (st[9].rm),
    .d     (st[9].rd),
    .terms (tout)
  );

  // check input, split day count, month total
  always_comb begin
    nx[0]       = st[0];
    nx[0].op    = req.op;
    nx[0].y     = req.year;
    nx[0].m     = req.month;
    nx[0].d     = req.day;
    nx[0].amt   = req.amount;
    nx[0].bad   = (req.year < YEAR_MIN) || (req.year > YEAR_MAX) || (req.month == 4'd0)
                  || (req.month > 4'd12) || (req.day == 5'd0)
                  || (req.day > dim_of(req.month, leap_of(req.year)));
    nx[0].tm    = tin;
    nx[0].total = 23'({9'd0, req.year} * 23'd12) + 23'(req.month) - 23'd1 + 23'(req.amount);
    nx[0].ry3   = 23'(req.year) + 23'(req.amount);
  end

  always_comb begin
    nx[1]      = st[0];
    nx[1].csum = 23'(st[0].tm.ya365) + 23'(st[0].tm.q4) - 23'(st[0].tm.q100)
                 + 23'(st[0].tm.q400) + 23'(st[0].tm.doy) + 23'(st[0].amt);
    nx[1].q12  = div12(st[0].total);
  end

  always_comb begin
    nx[2]     = st[1];
    nx[2].era = div146097(st[1].csum[21:0]);
    nx[2].r12 = 4'(st[1].total - 23'({3'd0, st[1].q12} * 23'd12));
    case (st[1].op)
      OP_ADD_DAYS:   nx[2].ovf = st[1].csum >= DAY_LIMIT;
      OP_ADD_MONTHS: nx[2].ovf = st[1].q12 > 20'(YEAR_MAX);
      OP_ADD_YEARS:  nx[2].ovf = st[1].ry3 > 23'(YEAR_MAX);
      default:       nx[2].ovf = 1'b0;
    endcase
  end

  always_comb begin
    nx[3]     = st[2];
    nx[3].doe = 18'(st[2].csum - 23'({18'd0, st[2].era} * 23'd146097));
  end

  always_comb begin
    nx[4]         = st[3];
    nx[4].a1460   = div1460(st[3].doe);
    nx[4].b36524  = div36524(st[3].doe);
    nx[4].c146096 = st[3].doe == ERA_LAST;
  end

  always_comb begin
    nx[5]     = st[4];
    nx[5].yoe = div365(st[4].doe - 18'(st[4].a1460) + 18'(st[4].b36524)
                       - 18'(st[4].c146096));
  end

  always_comb begin
    nx[6]      = st[5];
    nx[6].doyb = 9'(st[5].doe - (18'({8'd0, st[5].yoe} * 18'd365) + 18'(st[5].yoe[9:2])
                 - 18'(div100(14'(st[5].yoe)))));
  end

  always_comb begin
    nx[7]    = st[6];
    nx[7].mp = div153(11'({2'd0, st[6].doyb} * 11'd5) + 11'd2);
  end

  // rebuild date from count, pick result date by op
  always_comb begin
    nx[8] = st[7];
    m3    = (st[7].mp < 4'd10) ? st[7].mp + 4'd3 : st[7].mp - 4'd9;
    case (st[7].op)
      OP_ADD_DAYS: begin
        nx[8].ry  = 14'(st[7].yoe) + 14'({9'd0, st[7].era} * 14'd400)
                    + ((m3 <= 4'd2) ? 14'd1 : 14'd0);
        nx[8].rm  = m3;
        nx[8].rdp = 5'(st[7].doyb - div5(11'({7'd0, st[7].mp} * 11'd153) + 11'd2) + 9'd1);
      end
      OP_ADD_MONTHS: begin
        nx[8].ry  = st[7].q12[13:0];
        nx[8].rm  = st[7].r12 + 4'd1;
        nx[8].rdp = st[7].d;
      end
      OP_ADD_YEARS: begin
        nx[8].ry  = st[7].ry3[13:0];
        nx[8].rm  = st[7].m;
        nx[8].rdp = st[7].d;
      end
      default: begin
        nx[8].ry  = st[7].y;
        nx[8].rm  = st[7].m;
        nx[8].rdp = st[7].d;
      end
    endcase
  end

  // clamp day, settle status
  always_comb begin
    nx[9] = st[8];
    lim   = dim_of(st[8].rm, leap_of(st[8].ry));
    if ((st[8].op == OP_ADD_MONTHS || st[8].op == OP_ADD_YEARS) && st[8].rdp > lim) begin
      nx[9].rd = lim;
    end else begin
      nx[9].rd = st[8].rdp;
    end
    if (st[8].bad) begin
      nx[9].status = ST_BAD_DATE;
    end else if (st[8].ovf) begin
      nx[9].status = ST_RANGE;
    end else begin
      nx[9].status = ST_OK;
    end
  end

  always_comb begin
    nx[10]    = st[9];
    nx[10].tm = tout;
  end

  always_comb begin
    nx[11]      = st[10];
    nx[11].fcnt = st[10].tm.ya365 + 22'(st[10].tm.q4) - 22'(st[10].tm.q100)
                  + 22'(st[10].tm.q400) + 22'(st[10].tm.doy);
  end

  always_comb begin
    nx[12]    = st[11];
    nx[12].q7 = div7(st[11].fcnt);
  end

  always_comb begin
    rem7     = st[12].fcnt - 22'({2'd0, st[12].q7} * 22'd7);
    rsp_next = '0;
    rsp_next.status = st[12].status;
    if (st[12].status == ST_OK) begin
      rsp_next.out_year  = st[12].ry;
      rsp_next.out_month = st[12].rm;
      rsp_next.out_day   = st[12].rd;
      rsp_next.weekday   = (rem7[2:0] >= 3'd4) ? rem7[2:0] - 3'd4 : rem7[2:0] + 3'd3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < NST; k++) begin
        st[k] <= nx[k];
      end
      rsp <= rsp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      rsp_valid <= 1'b0;
    end else if (adv) begin
      vld       <= {vld[NST-2:0], req_valid};
      rsp_valid <= vld[NST-1];
    end
  end

  a_enter: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> vld[0])
    else $error("accepted item missing from first stage");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != ST_OK |-> rsp.out_year == 14'd0 && rsp.out_month == 4'd0
      && rsp.out_day == 5'd0 && rsp.weekday == 3'd0)
    else $error("fields not cleared on error status");

  a_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == ST_OK |-> rsp.out_year >= YEAR_MIN
      && rsp.out_year <= YEAR_MAX && rsp.out_month >= 4'd1 && rsp.out_month <= 4'd12
      && rsp.out_day >= 5'd1 && rsp.weekday <= 3'd6)
    else $error("result date out of range");

  a_clamp: assert property (@(posedge clk) disable iff (rst)
    vld[9] && st[9].status == ST_OK
      && (st[9].op == OP_ADD_MONTHS || st[9].op == OP_ADD_YEARS) |-> st[9].rd <= st[9].d)
    else $error("clamped day above input day");

endmodule
